FILE: rtl/core/cscc_pkg.sv
package cscc_pkg;

    localparam int unsigned POS_W  = 25;
    localparam int unsigned CUR_W  = 12;
    localparam int unsigned LVL_W  = 13;
    localparam int unsigned RATE_W = 25;
    localparam int unsigned DLY_W  = 16;
    localparam int unsigned RUN_W  = 32;
    localparam int unsigned REP_W  = 11;
    localparam int unsigned RBC_W  = 9;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [POS_W-1:0] POS_FULL  = 25'h100_0000;
    localparam logic [POS_W-1:0] POS_HALF  = 25'h080_0000;
    localparam logic [POS_W-1:0] NEAR_BAND = 25'd167772;

    localparam int unsigned DEF_ROLLBACK_AMOUNT   = 0;
    localparam int unsigned DEF_MALFUNCTION_CHECK = 1;
    localparam int unsigned DEF_ROLLBACK_DELAY_MS = 300;
    localparam int unsigned DEF_REPORT_PERIOD_MS  = 1000;

    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_STOP   = 2'd1,
        REQ_TOGGLE = 2'd2,
        REQ_GOTO   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_OPEN_END    = 3'd1,
        EV_CLOSED_END  = 3'd2,
        EV_OBSTACLE    = 3'd3,
        EV_MALFUNCTION = 3'd4,
        EV_TIMEOUT     = 3'd5,
        EV_AT_TARGET   = 3'd6,
        EV_STOPPED     = 3'd7
    } ev_t;

    localparam logic [2:0] REG_OPEN_MOVING    = 3'd0;
    localparam logic [2:0] REG_CLOSE_MOVING   = 3'd1;
    localparam logic [2:0] REG_OPEN_OBSTACLE  = 3'd2;
    localparam logic [2:0] REG_CLOSE_OBSTACLE = 3'd3;
    localparam logic [2:0] REG_OPEN_RATE      = 3'd4;
    localparam logic [2:0] REG_CLOSE_RATE     = 3'd5;
    localparam logic [2:0] REG_SENSING_DELAY  = 3'd6;
    localparam logic [2:0] REG_MAX_RUN        = 3'd7;

    typedef struct packed {
        logic [CUR_W-1:0]  open_moving_level;
        logic [CUR_W-1:0]  close_moving_level;
        logic [LVL_W-1:0]  open_obstacle_level;
        logic [LVL_W-1:0]  close_obstacle_level;
        logic [RATE_W-1:0] open_rate;
        logic [RATE_W-1:0] close_rate;
        logic [DLY_W-1:0]  sensing_delay_ms;
        logic [RUN_W-1:0]  max_run_ms;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic              last_close;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  target;
        logic [RUN_W-1:0]  run_ms;
        logic [REP_W-1:0]  report_ms;
        logic [RBC_W-1:0]  rb_count;
        logic              rb_pending;
        logic              rb_to_open;
    } state_t;

    typedef struct packed {
        op_t              drive;
        logic [POS_W-1:0] pos;
        ev_t              event_code;
        logic             report;
    } result_t;

endpackage

FILE: rtl/core/current_sensed_cover_controller.sv
// Motorized cover controller with current sensing and time-based position.
//
// Request channel: in_valid/in_stall with req_type (tick, stop, toggle, go to
// position), goal_position and the two sampled motor currents. One request
// is sent per 1 ms tick plus any commands.
// Result channel: out_valid/out_stall with motor_drive, estimated_position,
// event_code and report_state; exactly one result per request, in order.
// Registers are written over the APB port (byte address 4*index). The user must
// write only while no request is in flight; the block does not enforce it.
// Reads return the stored values, pready is tied high.
//
// A request passes from the input register through the single-pass update
// into the result register. Throughput: one request per cycle while the result
// is not stalled; the update is a short chain of add, compare and select logic.
// A stalled result holds; the input register still takes one more request,
// after which in_stall rises until the result is taken.
// Reset: cover idle, position half open, registers at their defaults.
module current_sensed_cover_controller #(
    parameter int unsigned ROLLBACK_AMOUNT   = cscc_pkg::DEF_ROLLBACK_AMOUNT,
    parameter int unsigned MALFUNCTION_CHECK = cscc_pkg::DEF_MALFUNCTION_CHECK,
    parameter int unsigned ROLLBACK_DELAY_MS = cscc_pkg::DEF_ROLLBACK_DELAY_MS,
    parameter int unsigned REPORT_PERIOD_MS  = cscc_pkg::DEF_REPORT_PERIOD_MS
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic [cscc_pkg::POS_W-1:0]    goal_position,
    input  logic [cscc_pkg::CUR_W-1:0]    open_current,
    input  logic [cscc_pkg::CUR_W-1:0]    close_current,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    motor_drive,
    output logic [cscc_pkg::POS_W-1:0]    estimated_position,
    output logic [2:0]                    event_code,
    output logic                          report_state,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cscc_pkg::ADDR_W-1:0]   paddr,
    input  logic [cscc_pkg::DATA_W-1:0]   pwdata,
    output logic [cscc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    cscc_pkg::cfg_t    cfg_reg;
    cscc_pkg::state_t  state_reg;
    cscc_pkg::state_t  state_next;
    cscc_pkg::result_t result_next;
    cscc_pkg::result_t res_reg;

    logic                        in_vld_reg;
    cscc_pkg::req_t              req_reg;
    logic [cscc_pkg::POS_W-1:0]  goal_reg;
    logic [cscc_pkg::CUR_W-1:0]  oc_reg;
    logic [cscc_pkg::CUR_W-1:0]  cc_reg;
    logic                        out_vld_reg;

    logic                        advance;
    logic                        in_take;
    logic                        cfg_wr;
    logic [2:0]                  cfg_idx;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_moving_level    <= 12'd100;
            cfg_reg.close_moving_level   <= 12'd100;
            cfg_reg.open_obstacle_level  <= 13'd4096;
            cfg_reg.close_obstacle_level <= 13'd4096;
            cfg_reg.open_rate            <= 25'd1678;
            cfg_reg.close_rate           <= 25'd1678;
            cfg_reg.sensing_delay_ms     <= 16'd1000;
            cfg_reg.max_run_ms           <= '1;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                cscc_pkg::REG_OPEN_MOVING:
                    cfg_reg.open_moving_level <= pwdata[cscc_pkg::CUR_W-1:0];
                cscc_pkg::REG_CLOSE_MOVING:
                    cfg_reg.close_moving_level <= pwdata[cscc_pkg::CUR_W-1:0];
                cscc_pkg::REG_OPEN_OBSTACLE:
                    cfg_reg.open_obstacle_level <= pwdata[cscc_pkg::LVL_W-1:0];
                cscc_pkg::REG_CLOSE_OBSTACLE:
                    cfg_reg.close_obstacle_level <= pwdata[cscc_pkg::LVL_W-1:0];
                cscc_pkg::REG_OPEN_RATE:
                    cfg_reg.open_rate <= pwdata[cscc_pkg::RATE_W-1:0];
                cscc_pkg::REG_CLOSE_RATE:
                    cfg_reg.close_rate <= pwdata[cscc_pkg::RATE_W-1:0];
                cscc_pkg::REG_SENSING_DELAY:
                    cfg_reg.sensing_delay_ms <= pwdata[cscc_pkg::DLY_W-1:0];
                cscc_pkg::REG_MAX_RUN:
                    cfg_reg.max_run_ms <= pwdata[cscc_pkg::RUN_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            cscc_pkg::REG_OPEN_MOVING:
                prdata = cscc_pkg::DATA_W'(cfg_reg.open_moving_level);
            cscc_pkg::REG_CLOSE_MOVING:
                prdata = cscc_pkg::DATA_W'(cfg_reg.close_moving_level);
            cscc_pkg::REG_OPEN_OBSTACLE:
                prdata = cscc_pkg::DATA_W'(cfg_reg.open_obstacle_level);
            cscc_pkg::REG_CLOSE_OBSTACLE:
                prdata = cscc_pkg::DATA_W'(cfg_reg.close_obstacle_level);
            cscc_pkg::REG_OPEN_RATE:
                prdata = cscc_pkg::DATA_W'(cfg_reg.open_rate);
            cscc_pkg::REG_CLOSE_RATE:
                prdata = cscc_pkg::DATA_W'(cfg_reg.close_rate);
            cscc_pkg::REG_SENSING_DELAY:
                prdata = cscc_pkg::DATA_W'(cfg_reg.sensing_delay_ms);
            cscc_pkg::REG_MAX_RUN:
                prdata = cfg_reg.max_run_ms;
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg  <= cscc_pkg::req_t'(req_type);
            goal_reg <= goal_position;
            oc_reg   <= open_current;
            cc_reg   <= close_current;
        end
    end

    cscc_step #(
        .ROLLBACK_AMOUNT   (ROLLBACK_AMOUNT),
        .MALFUNCTION_CHECK (MALFUNCTION_CHECK),
        .ROLLBACK_DELAY_MS (ROLLBACK_DELAY_MS),
        .REPORT_PERIOD_MS  (REPORT_PERIOD_MS)
    ) u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .req        (req_reg),
        .goal       (goal_reg),
        .oc         (oc_reg),
        .cc         (cc_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.op         <= cscc_pkg::OP_IDLE;
            state_reg.last_close <= 1'b0;
            state_reg.pos        <= cscc_pkg::POS_HALF;
            state_reg.target     <= '0;
            state_reg.run_ms     <= '0;
            state_reg.report_ms  <= '0;
            state_reg.rb_count   <= '0;
            state_reg.rb_pending <= 1'b0;
            state_reg.rb_to_open <= 1'b0;
            out_vld_reg          <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg   <= state_next;
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result_next;
        end
    end

    assign out_valid          = out_vld_reg;
    assign motor_drive        = res_reg.drive;
    assign estimated_position = res_reg.pos;
    assign event_code         = res_reg.event_code;
    assign report_state       = res_reg.report;

    // any stop event leaves the motor idle and asks for a report
    a_event_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (res_reg.event_code != cscc_pkg::EV_NONE)
            |-> res_reg.report && (res_reg.drive == cscc_pkg::OP_IDLE))
        else $error("stop event without idle drive and report");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pos <= cscc_pkg::POS_FULL)
        else $error("position estimate beyond fully open");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg && (res_reg.pos == state_reg.pos)
                    && (res_reg.drive == state_reg.op))
        else $error("result register does not match updated state");

    a_rollback_off: assert property (@(posedge clk) disable iff (!rst_n)
        (ROLLBACK_AMOUNT == 0) |-> !state_reg.rb_pending)
        else $error("rollback pending with rollback disabled");

endmodule

FILE: rtl/core/cscc_step.sv
module cscc_step #(
    parameter int unsigned ROLLBACK_AMOUNT   = cscc_pkg::DEF_ROLLBACK_AMOUNT,
    parameter int unsigned MALFUNCTION_CHECK = cscc_pkg::DEF_MALFUNCTION_CHECK,
    parameter int unsigned ROLLBACK_DELAY_MS = cscc_pkg::DEF_ROLLBACK_DELAY_MS,
    parameter int unsigned REPORT_PERIOD_MS  = cscc_pkg::DEF_REPORT_PERIOD_MS
) (
    input  cscc_pkg::state_t                   state,
    input  cscc_pkg::cfg_t                     cfg,
    input  cscc_pkg::req_t                     req,
    input  logic [cscc_pkg::POS_W-1:0]         goal,
    input  logic [cscc_pkg::CUR_W-1:0]         oc,
    input  logic [cscc_pkg::CUR_W-1:0]         cc,
    output cscc_pkg::state_t                   state_next,
    output cscc_pkg::result_t                  result
);

    localparam logic [cscc_pkg::POS_W-1:0] RB_AMT   = cscc_pkg::POS_W'(ROLLBACK_AMOUNT);
    localparam logic [cscc_pkg::RBC_W-1:0] RB_DELAY = cscc_pkg::RBC_W'(ROLLBACK_DELAY_MS);
    localparam logic [cscc_pkg::REP_W-1:0] REP_PER  = cscc_pkg::REP_W'(REPORT_PERIOD_MS);
    localparam logic MAL_EN = (MALFUNCTION_CHECK != 0);
    localparam logic RB_EN  = (ROLLBACK_AMOUNT != 0);

    logic [cscc_pkg::POS_W-1:0] goal_sat;
    logic [cscc_pkg::POS_W-1:0] goal_diff;
    logic [cscc_pkg::RBC_W-1:0] rb_dec;
    logic                       rb_fire;
    logic [cscc_pkg::POS_W:0]   rb_up_sum;
    logic [cscc_pkg::POS_W-1:0] rb_up;
    logic [cscc_pkg::POS_W-1:0] rb_dn;
    logic [cscc_pkg::REP_W-1:0] rep_inc;
    logic [cscc_pkg::RUN_W-1:0] run_inc;
    logic [cscc_pkg::POS_W:0]   pos_up_sum;
    logic [cscc_pkg::POS_W-1:0] pos_up;
    logic [cscc_pkg::POS_W-1:0] pos_dn;
    logic [cscc_pkg::POS_W-1:0] pos_mv;
    logic                       delay_over;
    logic                       oc_moving;
    logic                       cc_moving;
    logic                       oc_obstacle;
    logic                       cc_obstacle;

    function automatic cscc_pkg::state_t begin_move(cscc_pkg::state_t s, cscc_pkg::op_t dir);
        cscc_pkg::state_t r;
        r = s;
        if (dir != s.op)
        begin
            if (dir != cscc_pkg::OP_IDLE)
            begin
                r.last_close = (dir == cscc_pkg::OP_CLOSE);
            end
            r.op     = dir;
            r.run_ms = '0;
        end
        return r;
    endfunction

    assign goal_sat  = (goal > cscc_pkg::POS_FULL) ? cscc_pkg::POS_FULL : goal;
    assign goal_diff = (goal_sat > state.pos) ? goal_sat - state.pos : state.pos - goal_sat;

    assign rb_dec    = (state.rb_count != '0) ? state.rb_count - 1'b1 : '0;
    assign rb_fire   = state.rb_pending && (rb_dec == '0);
    assign rb_up_sum = {1'b0, state.pos} + {1'b0, RB_AMT};
    assign rb_up     = (rb_up_sum > {1'b0, cscc_pkg::POS_FULL}) ? cscc_pkg::POS_FULL
                                                                 : rb_up_sum[cscc_pkg::POS_W-1:0];
    assign rb_dn     = (state.pos > RB_AMT) ? state.pos - RB_AMT : '0;

    assign rep_inc = (state.report_ms != '1) ? state.report_ms + 1'b1 : state.report_ms;
    assign run_inc = (state.run_ms != '1) ? state.run_ms + 1'b1 : state.run_ms;

    assign pos_up_sum = {1'b0, state.pos} + {1'b0, cfg.open_rate};
    assign pos_up     = (pos_up_sum > {1'b0, cscc_pkg::POS_FULL}) ? cscc_pkg::POS_FULL
                                                                   : pos_up_sum[cscc_pkg::POS_W-1:0];
    assign pos_dn     = (state.pos > cfg.close_rate) ? state.pos - cfg.close_rate : '0;
    assign pos_mv     = (state.op == cscc_pkg::OP_OPEN) ? pos_up : pos_dn;

    assign delay_over  = run_inc > {{(cscc_pkg::RUN_W-cscc_pkg::DLY_W){1'b0}}, cfg.sensing_delay_ms};
    assign oc_moving   = oc > cfg.open_moving_level;
    assign cc_moving   = cc > cfg.close_moving_level;
    assign oc_obstacle = {1'b0, oc} > cfg.open_obstacle_level;
    assign cc_obstacle = {1'b0, cc} > cfg.close_obstacle_level;

    always_comb
    begin
        cscc_pkg::state_t nx;
        cscc_pkg::ev_t    ev;
        logic             obstacle;
        logic             hit_target;
        logic             stopped;
        logic             report;

        nx         = state;
        ev         = cscc_pkg::EV_NONE;
        obstacle   = 1'b0;
        hit_target = 1'b0;
        stopped    = 1'b0;
        report     = 1'b0;

        unique case (req)
            cscc_pkg::REQ_STOP:
            begin
                nx     = begin_move(state, cscc_pkg::OP_IDLE);
                ev     = cscc_pkg::EV_STOPPED;
                report = 1'b1;
            end
            cscc_pkg::REQ_TOGGLE:
            begin
                if (state.op != cscc_pkg::OP_IDLE)
                begin
                    nx     = begin_move(state, cscc_pkg::OP_IDLE);
                    ev     = cscc_pkg::EV_STOPPED;
                    report = 1'b1;
                end
                else if (state.pos == '0 || state.last_close)
                begin
                    nx        = begin_move(state, cscc_pkg::OP_OPEN);
                    nx.target = cscc_pkg::POS_FULL;
                end
                else
                begin
                    nx        = begin_move(state, cscc_pkg::OP_CLOSE);
                    nx.target = '0;
                end
            end
            cscc_pkg::REQ_GOTO:
            begin
                // ignore goals inside the near band
                if (goal_diff > cscc_pkg::NEAR_BAND)
                begin
                    nx = begin_move(state, (goal_sat < state.pos) ? cscc_pkg::OP_CLOSE
                                                                   : cscc_pkg::OP_OPEN);
                    nx.target = goal_sat;
                end
            end
            cscc_pkg::REQ_TICK:
            begin
                if (rb_fire)
                begin
                    // rollback wait expired: start the reverse move, nothing else
                    nx            = begin_move(state, state.rb_to_open ? cscc_pkg::OP_OPEN
                                                                       : cscc_pkg::OP_CLOSE);
                    nx.rb_count   = rb_dec;
                    nx.rb_pending = 1'b0;
                    nx.target     = state.rb_to_open ? rb_up : rb_dn;
                end
                else
                begin
                    nx.rb_count  = state.rb_pending ? rb_dec : state.rb_count;
                    nx.report_ms = rep_inc;
                    if (state.op != cscc_pkg::OP_IDLE)
                    begin
                        nx.pos = pos_mv;
                        if (state.op == cscc_pkg::OP_OPEN)
                        begin
                            hit_target = (state.target == cscc_pkg::POS_FULL)
                                       ? (delay_over && !oc_moving) : (pos_mv >= state.target);
                            if (MAL_EN && cc_moving)
                            begin
                                ev = cscc_pkg::EV_MALFUNCTION;
                            end
                            else if (oc_obstacle)
                            begin
                                ev       = cscc_pkg::EV_OBSTACLE;
                                obstacle = 1'b1;
                            end
                            else if (delay_over && !oc_moving)
                            begin
                                ev     = cscc_pkg::EV_OPEN_END;
                                nx.pos = cscc_pkg::POS_FULL;
                            end
                        end
                        else
                        begin
                            hit_target = (state.target == '0)
                                       ? (delay_over && !cc_moving) : (pos_mv <= state.target);
                            if (MAL_EN && oc_moving)
                            begin
                                ev = cscc_pkg::EV_MALFUNCTION;
                            end
                            else if (cc_obstacle)
                            begin
                                ev       = cscc_pkg::EV_OBSTACLE;
                                obstacle = 1'b1;
                            end
                            else if (delay_over && !cc_moving)
                            begin
                                ev     = cscc_pkg::EV_CLOSED_END;
                                nx.pos = '0;
                            end
                        end

                        if (ev == cscc_pkg::EV_NONE && run_inc > cfg.max_run_ms)
                        begin
                            ev = cscc_pkg::EV_TIMEOUT;
                        end
                        else if (ev == cscc_pkg::EV_NONE && hit_target)
                        begin
                            ev = cscc_pkg::EV_AT_TARGET;
                        end

                        stopped = (ev != cscc_pkg::EV_NONE);
                        if (stopped)
                        begin
                            nx.op     = cscc_pkg::OP_IDLE;
                            nx.run_ms = '0;
                            report    = 1'b1;
                        end
                        else
                        begin
                            nx.run_ms = run_inc;
                            if (rep_inc >= REP_PER)
                            begin
                                report       = 1'b1;
                                nx.report_ms = '0;
                            end
                        end

                        if (RB_EN && obstacle)
                        begin
                            nx.rb_pending = 1'b1;
                            nx.rb_count   = RB_DELAY;
                            nx.rb_to_open = (state.op == cscc_pkg::OP_CLOSE);
                        end
                    end
                end
            end
            default:
            begin
                nx = state;
            end
        endcase

        state_next        = nx;
        result.drive      = nx.op;
        result.pos        = nx.pos;
        result.event_code = ev;
        result.report     = report;
    end

endmodule

FILE: tb/tb.sv
module tb;
    import cscc_pkg::*;

    typedef struct packed {
        req_t             req;
        logic [POS_W-1:0] goal;
        logic [CUR_W-1:0] oc;
        logic [CUR_W-1:0] cc;
    } cover_req_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;

    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          req_type = 2'd0;
    logic [POS_W-1:0]    goal_position = '0;
    logic [CUR_W-1:0]    open_current = '0;
    logic [CUR_W-1:0]    close_current = '0;

    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          motor_drive;
    logic [POS_W-1:0]    estimated_position;
    logic [2:0]          event_code;
    logic                report_state;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    cfg_t                cfg;
    state_t              cover_now;
    state_t              cover_ahead;
    cover_req_t          pending_cmds[$];
    result_t             expected_status[$];
    cover_req_t          next_cmd;
    cover_req_t          seen_req;
    logic                req_taken = 1'b0;
    int                  cmds_planned = 0;
    int                  results_checked = 0;
    int                  fault_count = 0;
    int                  sender_gap_pct = 6;
    int                  stall_pct = 46;

    current_sensed_cover_controller dut (
        .clk, .rst_n,
        .in_valid, .in_stall, .req_type, .goal_position, .open_current, .close_current,
        .out_valid, .out_stall, .motor_drive, .estimated_position, .event_code,
        .report_state,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #5 clk = ~clk;

    function automatic void start_motion(inout state_t s, input op_t dir);
        if (dir == s.op)
            return;
        if (dir != OP_IDLE)
            s.last_close = (dir == OP_CLOSE);
        s.op = dir;
        s.run_ms = '0;
    endfunction

    function automatic void arm_rollback(inout state_t s, input logic to_open);
        if (DEF_ROLLBACK_AMOUNT != 0)
        begin
            s.rb_pending = 1'b1;
            s.rb_count = RBC_W'(DEF_ROLLBACK_DELAY_MS);
            s.rb_to_open = to_open;
        end
    endfunction

    function automatic logic target_reached(input state_t s, input cfg_t c, input cover_req_t r);
        logic trusted;
        trusted = s.run_ms > c.sensing_delay_ms;
        if (s.op == OP_OPEN)
        begin
            if (s.target == POS_FULL)
                return trusted && !(r.oc > c.open_moving_level);
            return s.pos >= s.target;
        end
        if (s.op == OP_CLOSE)
        begin
            if (s.target == '0)
                return trusted && !(r.cc > c.close_moving_level);
            return s.pos <= s.target;
        end
        return 1'b1;
    endfunction

    // Advance the cover state by one request and return the status it answers with.
    function automatic result_t cover_step(inout state_t s, input cfg_t c, input cover_req_t r);
        logic [POS_W-1:0] goal;
        logic [POS_W-1:0] gap;
        logic [POS_W:0]   sum;
        int unsigned      rb_span;
        ev_t              ev;
        logic             rep;
        ev = EV_NONE;
        rep = 1'b0;
        case (r.req)
            REQ_STOP:
            begin
                start_motion(s, OP_IDLE);
                return result_t'{s.op, s.pos, EV_STOPPED, 1'b1};
            end
            REQ_TOGGLE:
            begin
                if (s.op != OP_IDLE)
                begin
                    start_motion(s, OP_IDLE);
                    return result_t'{s.op, s.pos, EV_STOPPED, 1'b1};
                end
                if (s.pos == '0 || s.last_close)
                begin
                    s.target = POS_FULL;
                    start_motion(s, OP_OPEN);
                end
                else
                begin
                    s.target = '0;
                    start_motion(s, OP_CLOSE);
                end
                return result_t'{s.op, s.pos, EV_NONE, 1'b0};
            end
            REQ_GOTO:
            begin
                goal = (r.goal > POS_FULL) ? POS_FULL : r.goal;
                gap = (goal > s.pos) ? goal - s.pos : s.pos - goal;
                if (gap > NEAR_BAND)
                begin
                    s.target = goal;
                    if (goal < s.pos)
                        start_motion(s, OP_CLOSE);
                    else
                        start_motion(s, OP_OPEN);
                end
                return result_t'{s.op, s.pos, EV_NONE, 1'b0};
            end
            default: ;
        endcase

        // an expiring rollback wait takes the whole tick
        if (s.rb_pending)
        begin
            if (s.rb_count != '0)
                s.rb_count--;
            if (s.rb_count == '0)
            begin
                s.rb_pending = 1'b0;
                if (s.rb_to_open)
                begin
                    rb_span = s.pos + DEF_ROLLBACK_AMOUNT;
                    s.target = (rb_span > POS_FULL) ? POS_FULL : rb_span[POS_W-1:0];
                    start_motion(s, OP_OPEN);
                end
                else
                begin
                    s.target = (s.pos > DEF_ROLLBACK_AMOUNT) ?
                               POS_W'(s.pos - DEF_ROLLBACK_AMOUNT) : '0;
                    start_motion(s, OP_CLOSE);
                end
                return result_t'{s.op, s.pos, EV_NONE, 1'b0};
            end
        end

        if (s.report_ms != '1)
            s.report_ms++;
        if (s.op == OP_IDLE)
            return result_t'{s.op, s.pos, EV_NONE, 1'b0};
        if (s.run_ms != '1)
            s.run_ms++;

        if (s.op == OP_OPEN)
        begin
            sum = {1'b0, s.pos} + {1'b0, c.open_rate};
            s.pos = (sum > POS_FULL) ? POS_FULL : sum[POS_W-1:0];
        end
        else
        begin
            s.pos = (s.pos > c.close_rate) ? s.pos - c.close_rate : '0;
        end

        if (s.op == OP_OPEN)
        begin
            if (DEF_MALFUNCTION_CHECK != 0 && r.cc > c.close_moving_level)
            begin
                start_motion(s, OP_IDLE);
                ev = EV_MALFUNCTION;
            end
            else if (r.oc > c.open_obstacle_level)
            begin
                start_motion(s, OP_IDLE);
                ev = EV_OBSTACLE;
                arm_rollback(s, 1'b0);
            end
            else if (s.run_ms > c.sensing_delay_ms && !(r.oc > c.open_moving_level))
            begin
                start_motion(s, OP_IDLE);
                s.pos = POS_FULL;
                ev = EV_OPEN_END;
            end
        end
        else
        begin
            if (DEF_MALFUNCTION_CHECK != 0 && r.oc > c.open_moving_level)
            begin
                start_motion(s, OP_IDLE);
                ev = EV_MALFUNCTION;
            end
            else if (r.cc > c.close_obstacle_level)
            begin
                start_motion(s, OP_IDLE);
                ev = EV_OBSTACLE;
                arm_rollback(s, 1'b1);
            end
            else if (s.run_ms > c.sensing_delay_ms && !(r.cc > c.close_moving_level))
            begin
                start_motion(s, OP_IDLE);
                s.pos = '0;
                ev = EV_CLOSED_END;
            end
        end
        if (s.op != OP_IDLE && s.run_ms > c.max_run_ms)
        begin
            start_motion(s, OP_IDLE);
            ev = EV_TIMEOUT;
        end
        if (s.op != OP_IDLE && target_reached(s, c, r))
        begin
            start_motion(s, OP_IDLE);
            ev = EV_AT_TARGET;
        end
        if (ev != EV_NONE)
            rep = 1'b1;
        if (s.op != OP_IDLE && s.report_ms >= DEF_REPORT_PERIOD_MS)
        begin
            rep = 1'b1;
            s.report_ms = '0;
        end
        return result_t'{s.op, s.pos, ev, rep};
    endfunction

    function automatic void report_fault(input string msg);
        if (fault_count < 10)
            $display("%s", msg);
        fault_count++;
    endfunction

    // Queue one request and track where the cover will be once it has been served.
    task automatic queue_cmd(input req_t q, input logic [POS_W-1:0] goal,
                             input logic [CUR_W-1:0] oc, input logic [CUR_W-1:0] cc);
        cover_req_t r;
        r = cover_req_t'{q, goal, oc, cc};
        pending_cmds.push_back(r);
        void'(cover_step(cover_ahead, cfg, r));
        cmds_planned++;
    endtask

    task automatic queue_random(input int count);
        int               pick;
        int               run_lvl;
        int               run_obst;
        int               opp_lvl;
        int               hi;
        int               run_cur;
        int               opp_cur;
        logic [POS_W-1:0] goal;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            goal = POS_W'($urandom());
            if (cover_ahead.op == OP_IDLE)
            begin
                if (pick < 30)
                begin
                    case ($urandom_range(4))
                        0: goal = '0;
                        1: goal = POS_FULL;
                        2: goal = cover_ahead.pos + POS_W'($urandom_range(NEAR_BAND + 2000));
                        3: goal = POS_W'($urandom_range(POS_FULL));
                        default: ;
                    endcase
                    queue_cmd(REQ_GOTO, goal, CUR_W'($urandom()), CUR_W'($urandom()));
                end
                else if (pick < 50)
                begin
                    queue_cmd(REQ_TOGGLE, goal, CUR_W'($urandom()), CUR_W'($urandom()));
                end
                else if (pick < 55)
                begin
                    queue_cmd(REQ_STOP, goal, CUR_W'($urandom()), CUR_W'($urandom()));
                end
                else
                begin
                    queue_cmd(REQ_TICK, goal, CUR_W'($urandom()), CUR_W'($urandom()));
                end
            end
            else
            begin
                if (cover_ahead.op == OP_OPEN)
                begin
                    run_lvl = int'(cfg.open_moving_level);
                    run_obst = int'(cfg.open_obstacle_level);
                    opp_lvl = int'(cfg.close_moving_level);
                end
                else
                begin
                    run_lvl = int'(cfg.close_moving_level);
                    run_obst = int'(cfg.close_obstacle_level);
                    opp_lvl = int'(cfg.open_moving_level);
                end
                // a healthy run: driven circuit above moving level, below obstacle level
                hi = (run_obst > 4095) ? 4095 : run_obst;
                run_cur = (run_lvl < hi) ? $urandom_range(hi, run_lvl + 1) : $urandom_range(4095);
                opp_cur = $urandom_range(opp_lvl);
                if (pick < 4)
                begin
                    queue_cmd(REQ_STOP, goal, CUR_W'(run_cur), CUR_W'(opp_cur));
                end
                else if (pick < 8)
                begin
                    queue_cmd(REQ_TOGGLE, goal, CUR_W'(run_cur), CUR_W'(opp_cur));
                end
                else if (pick < 12)
                begin
                    queue_cmd(REQ_GOTO, goal, CUR_W'(run_cur), CUR_W'(opp_cur));
                end
                else
                begin
                    if (pick < 16)
                    begin
                        run_cur = $urandom_range(4095);
                        opp_cur = $urandom_range(4095);
                    end
                    else if (pick < 20 && run_obst < 4095)
                    begin
                        run_cur = $urandom_range(4095, run_obst + 1);
                    end
                    else if (pick < 24 && opp_lvl < 4095)
                    begin
                        opp_cur = $urandom_range(4095, opp_lvl + 1);
                    end
                    else if (pick < 40 && cover_ahead.run_ms >= cfg.sensing_delay_ms)
                    begin
                        run_cur = $urandom_range(run_lvl);
                    end
                    if (cover_ahead.op == OP_OPEN)
                        queue_cmd(REQ_TICK, goal, CUR_W'(run_cur), CUR_W'(opp_cur));
                    else
                        queue_cmd(REQ_TICK, goal, CUR_W'(opp_cur), CUR_W'(run_cur));
                end
            end
        end
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic program_cover(input cfg_t c);
        apb_write(REG_OPEN_MOVING, DATA_W'(c.open_moving_level));
        apb_write(REG_CLOSE_MOVING, DATA_W'(c.close_moving_level));
        apb_write(REG_OPEN_OBSTACLE, DATA_W'(c.open_obstacle_level));
        apb_write(REG_CLOSE_OBSTACLE, DATA_W'(c.close_obstacle_level));
        apb_write(REG_OPEN_RATE, DATA_W'(c.open_rate));
        apb_write(REG_CLOSE_RATE, DATA_W'(c.close_rate));
        apb_write(REG_SENSING_DELAY, DATA_W'(c.sensing_delay_ms));
        apb_write(REG_MAX_RUN, c.max_run_ms);
        cfg = c;
    endtask

    function automatic cfg_t phase_setting(input int p);
        cfg_t c;
        case (p)
            1: c = cfg_t'{12'd100, 12'd100, 13'd500, 13'd600, 25'd16777216, 25'd0,
                          16'd0, 32'hFFFF_FFFF};
            2: c = cfg_t'{12'd0, 12'd4095, 13'd4096, 13'd0, RATE_W'(1 << 20),
                          RATE_W'(1 << 20), 16'd3, 32'd0};
            4: c = cfg_t'{12'd4095, 12'd0, 13'd4095, 13'd4095, 25'd1, 25'd16777216,
                          16'd65535, 32'd30};
            default:
            begin
                c.open_moving_level = CUR_W'($urandom_range(400));
                c.close_moving_level = CUR_W'($urandom_range(400));
                c.open_obstacle_level = ($urandom_range(3) == 0) ?
                                        LVL_W'(4096) : LVL_W'($urandom_range(4095, 1500));
                c.close_obstacle_level = ($urandom_range(3) == 0) ?
                                         LVL_W'(4096) : LVL_W'($urandom_range(4095, 1500));
                c.open_rate = RATE_W'($urandom_range(1 << 21, 1 << 16));
                c.close_rate = RATE_W'($urandom_range(1 << 21, 1 << 16));
                c.sensing_delay_ms = DLY_W'($urandom_range(30));
                c.max_run_ms = ($urandom_range(2) == 0) ? '1 : RUN_W'($urandom_range(80, 5));
            end
        endcase
        return c;
    endfunction

    // request side: present a new request once the previous one has been taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || req_taken)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_gap_pct)
                begin
                    next_cmd = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    req_type <= next_cmd.req;
                    goal_position <= next_cmd.goal;
                    open_current <= next_cmd.oc;
                    close_current <= next_cmd.cc;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_status.size() == 0)
            begin
                report_fault($sformatf("unexpected result: drive %0d pos %0d event %0d report %0b",
                                       motor_drive, estimated_position, event_code,
                                       report_state));
            end
            else
            begin
                want = expected_status.pop_front();
                results_checked++;
                if (motor_drive !== want.drive || estimated_position !== want.pos ||
                    event_code !== want.event_code || report_state !== want.report)
                    report_fault($sformatf({"mismatch: expected drive %0d pos %0d event %0d ",
                                            "report %0b, got drive %0d pos %0d event %0d ",
                                            "report %0b"},
                                           want.drive, want.pos, want.event_code, want.report,
                                           motor_drive, estimated_position, event_code,
                                           report_state));
            end
        end
        req_taken = rst_n && in_valid && !in_stall;
        if (req_taken)
        begin
            seen_req = cover_req_t'{req_t'(req_type), goal_position, open_current, close_current};
            expected_status.push_back(cover_step(cover_now, cfg, seen_req));
        end
    end

    initial
    begin
        cfg = cfg_t'{12'd100, 12'd100, 13'd4096, 13'd4096, 25'd1678, 25'd1678, 16'd1000,
                     32'hFFFF_FFFF};
        cover_now = state_t'{OP_IDLE, 1'b0, POS_HALF, '0, '0, '0, '0, 1'b0, 1'b0};
        cover_ahead = cover_now;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < 8; p++)
        begin
            if (p != 0)
                program_cover(phase_setting(p));
            sender_gap_pct = (p < 3) ? 6 : (p < 6) ? 46 : 0;
            stall_pct = (p < 3) ? 46 : (p < 6) ? 6 : 0;
            if (p == 0)
            begin
                // reset settings: commands, near goal, goal past open, no obstacle check
                queue_cmd(REQ_STOP, '0, '0, '0);
                queue_cmd(REQ_TICK, '1, '1, '1);
                queue_cmd(REQ_GOTO, POS_HALF + 25'd100, '0, '0);
                queue_cmd(REQ_GOTO, '1, '0, '0);
                queue_cmd(REQ_GOTO, '1, '0, '0);
                queue_cmd(REQ_TICK, '0, '1, '0);
                queue_cmd(REQ_GOTO, '0, '0, '0);
                queue_cmd(REQ_TICK, '0, '0, 12'd300);
                queue_cmd(REQ_TOGGLE, '0, '0, '0);
                queue_cmd(REQ_TOGGLE, '0, '0, '0);
                queue_cmd(REQ_TICK, '0, 12'd300, '1);
                queue_cmd(REQ_TOGGLE, '0, '0, '0);
                queue_cmd(REQ_TICK, '0, '1, 12'd300);
            end
            if (p == 1)
            begin
                // full-travel open rate, zero close rate, no sensing delay
                queue_cmd(REQ_GOTO, '0, '0, '0);
                queue_cmd(REQ_TICK, '0, '0, 12'd200);
                queue_cmd(REQ_TICK, '0, '0, 12'd50);
                queue_cmd(REQ_TOGGLE, '0, '0, '0);
                queue_cmd(REQ_TICK, '0, 12'd200, '0);
                queue_cmd(REQ_TICK, '0, 12'd80, '0);
                queue_cmd(REQ_GOTO, '0, '0, '0);
                queue_cmd(REQ_TICK, '0, '0, 12'd700);
                queue_cmd(REQ_GOTO, POS_HALF, '0, '0);
                queue_cmd(REQ_GOTO, '1, '0, '0);
                queue_cmd(REQ_TICK, '0, 12'd600, '0);
            end
            queue_random((p == 0) ? 100 : 108);
            while (results_checked != cmds_planned)
                @(negedge clk);
            repeat (4) @(negedge clk);
        end
        fault_count += expected_status.size();
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
